// ===== design/wac_pkg.sv =====
// ----------------------------------------------------------------------------
// Warp access coalescer package
// Shared sizes, types and register codes for the coalescer and its parts.
// ----------------------------------------------------------------------------
`default_nettype none

package wac_pkg;

    // Lanes in the widest warp, and width of an element index.
    localparam int MAX_LANES  = 32;
    localparam int INDEX_BITS = 24;

    // Fixed field widths.
    localparam int ADDR_BITS  = 32;
    localparam int LOG2_BITS  = 4;
    localparam int WARP_BITS  = 6;
    localparam int RUN_BITS   = 14;
    localparam int DATA_BITS  = 32;
    localparam int PADDR_BITS = 4;

    // Derived widths.
    localparam int LANE_BITS  = $clog2(MAX_LANES + 1);
    localparam int CMP_BITS   = (LANE_BITS > WARP_BITS) ? LANE_BITS : WARP_BITS;
    localparam int MAX_SHIFT  = (1 << LOG2_BITS) - 1;
    localparam int SHIFT_BITS = (INDEX_BITS + MAX_SHIFT > ADDR_BITS) ?
                                (INDEX_BITS + MAX_SHIFT) : ADDR_BITS;

    // Saturation value of the run counter.
    localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

    // Register indexes on the configuration port (paddr[3:2]).
    typedef enum logic [1:0] {
        REG_ELEMENT_SIZE_LOG2 = 2'd0,
        REG_LINE_SIZE_LOG2    = 2'd1,
        REG_WARP_SIZE         = 2'd2
    } reg_index_t;

    // Reset values of the configuration registers.
    localparam logic [LOG2_BITS-1:0] ELEMENT_SIZE_LOG2_RST = 4'd2;
    localparam logic [LOG2_BITS-1:0] LINE_SIZE_LOG2_RST    = 4'd7;
    localparam logic [WARP_BITS-1:0] WARP_SIZE_RST         = 6'd32;

    typedef logic [ADDR_BITS-1:0]  line_t;
    typedef logic [INDEX_BITS-1:0] index_t;

    // Control from the top level to the line set.
    typedef struct packed {
        logic insert;  // a lane's line enters the set this cycle
        logic flush;   // the warp closes with this lane
    } set_ctrl_t;

endpackage

`default_nettype wire

// ===== design/wac_channels.sv =====
// ----------------------------------------------------------------------------
// Coalescer channels
// Valid/ready channels for lane words in and line address words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface wac_in_if;
    import wac_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] element_index;
    logic                  end_of_row;
    logic                  first_of_pass;

    modport source (output valid, element_index, end_of_row, first_of_pass,
                    input ready);
    modport sink   (input valid, element_index, end_of_row, first_of_pass,
                    output ready);
endinterface

interface wac_out_if;
    import wac_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] line_address;
    logic                 last_of_warp;
    logic                 fully_coalesced;

    modport source (output valid, line_address, last_of_warp, fully_coalesced,
                    input ready);
    modport sink   (input valid, line_address, last_of_warp, fully_coalesced,
                    output ready);
endinterface

`default_nettype wire

// ===== design/wac_line_set.sv =====
// ----------------------------------------------------------------------------
// Coalescer line set
// Sorted, duplicate-free set of cache lines for the open warp. Every entry
// compares against the new line at once and the insert shifts every entry at once.
// ----------------------------------------------------------------------------
`default_nettype none

module wac_line_set (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  wac_pkg::set_ctrl_t                          ctrl,
    input  wac_pkg::line_t                              line,
    output wac_pkg::line_t [wac_pkg::MAX_LANES-1:0]     merged,
    output logic [wac_pkg::LANE_BITS-1:0]               merged_count
);
    import wac_pkg::*;

    line_t [MAX_LANES-1:0] entries_reg;
    logic  [LANE_BITS-1:0] count_reg;
    logic  [LANE_BITS-1:0] count_next;

    logic [MAX_LANES-1:0] below;
    logic [MAX_LANES-1:0] equal;
    logic                 do_insert;

    // Per-entry compare against the new line.
    genvar k;
    generate
        for (k = 0; k < MAX_LANES; k++)
        begin : g_cmp
            logic in_use;
            assign in_use   = count_reg > LANE_BITS'(k);
            assign below[k] = in_use && (entries_reg[k] < line);
            assign equal[k] = in_use && (entries_reg[k] == line);
        end
    endgenerate

    assign do_insert = !(|equal) && (count_reg != LANE_BITS'(MAX_LANES));

    // Entries below the new line stay, the slot at the boundary takes the
    // line, and everything above moves up one place.
    generate
        for (k = 0; k < MAX_LANES; k++)
        begin : g_merge
            if (k == 0)
            begin : g_first
                assign merged[k] = (!do_insert || below[k]) ? entries_reg[k] : line;
            end
            else
            begin : g_rest
                assign merged[k] = (!do_insert || below[k]) ? entries_reg[k] :
                                   below[k-1]              ? line :
                                                             entries_reg[k-1];
            end
        end
    endgenerate

    assign merged_count = count_reg + LANE_BITS'(do_insert);

    // A closing lane empties the set after its line has been merged.
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.insert)
        begin
            count_next = ctrl.flush ? '0 : merged_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Set contents need no reset: only entries below the count are used.
    always_ff @(posedge clk)
    begin
        if (ctrl.insert)
        begin
            entries_reg <= merged;
        end
    end

endmodule

`default_nettype wire

// ===== design/warp_access_coalescer.sv =====
// ----------------------------------------------------------------------------
// Warp access coalescer
// Groups lane element indices into warps and emits each warp's distinct
// cache line addresses in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one lane word per handshake: element index, end of row and
//   first of pass. out_ch carries one line address word per handshake, with
//   last_of_warp on the final line of a warp and the running contiguity flag.
//   The APB port sets element size, line size and warp size; write it only
//   while the block is idle.
//   A lane word lands in an input register and is merged into the sorted line
//   set from there, one lane per cycle while no closing lane waits. When a warp
//   closes, its lines move to an output shift register and appear on out_ch
//   from the following cycle, one per cycle while the receiver is ready: the
//   first line of a warp is valid in the cycle after its closing lane is taken.
//   Lanes keep flowing into the next warp while lines drain. A closing lane
//   waits in the input register until the previous warp's last line leaves,
//   which may be in the same cycle, so warps follow back to back while the
//   receiver keeps up. When the receiver stalls, the output holds and input
//   stalls once a second warp closes.
//   Reset empties the set and the output, sets the registers to element
//   size 4 bytes, line size 128 bytes, warp size 32, and sets the flag.
// ----------------------------------------------------------------------------
`default_nettype none

module warp_access_coalescer (
    input  logic                               clk,
    input  logic                               rst_n,
    wac_in_if.sink                             in_ch,
    wac_out_if.source                          out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wac_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [wac_pkg::DATA_BITS-1:0]      pwdata,
    output logic [wac_pkg::DATA_BITS-1:0]      prdata,
    output logic                               pready
);
    import wac_pkg::*;

    // Configuration registers.
    logic [LOG2_BITS-1:0] element_size_log2_reg;
    logic [LOG2_BITS-1:0] line_size_log2_reg;
    logic [WARP_BITS-1:0] warp_size_reg;
    logic                 cfg_write;
    reg_index_t           cfg_index;

    // Input register.
    logic   in_valid_reg;
    index_t index_reg;
    logic   end_of_row_reg;
    logic   first_of_pass_reg;

    // Per-warp and contiguity state.
    logic [LANE_BITS-1:0] lane_position_reg;
    logic [LANE_BITS-1:0] lane_position_next;
    logic [RUN_BITS-1:0]  run_counter_reg;
    logic [RUN_BITS-1:0]  run_counter_next;
    index_t               previous_index_reg;
    logic                 coalesced_flag_reg;
    logic                 coalesced_flag_next;

    // Output drain buffer.
    line_t [MAX_LANES-1:0] drain_reg;
    logic  [LANE_BITS-1:0] drain_count_reg;
    logic  [LANE_BITS-1:0] drain_count_next;
    logic                  drain_flag_reg;

    logic                  advance;
    logic                  close;
    logic                  out_take;
    logic                  drain_free;
    line_t                 line;
    logic [SHIFT_BITS-1:0] scaled;
    line_t                 line_mask;
    logic [CMP_BITS-1:0]   warp_limit;
    logic [CMP_BITS-1:0]   lanes_seen;
    set_ctrl_t             set_ctrl;
    line_t [MAX_LANES-1:0] merged;
    logic  [LANE_BITS-1:0] merged_count;

    // APB register access; writes take effect in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[PADDR_BITS-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_size_log2_reg <= ELEMENT_SIZE_LOG2_RST;
            line_size_log2_reg    <= LINE_SIZE_LOG2_RST;
            warp_size_reg         <= WARP_SIZE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ELEMENT_SIZE_LOG2: element_size_log2_reg <= pwdata[LOG2_BITS-1:0];
                REG_LINE_SIZE_LOG2:    line_size_log2_reg    <= pwdata[LOG2_BITS-1:0];
                REG_WARP_SIZE:         warp_size_reg         <= pwdata[WARP_BITS-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_ELEMENT_SIZE_LOG2: prdata = DATA_BITS'(element_size_log2_reg);
            REG_LINE_SIZE_LOG2:    prdata = DATA_BITS'(line_size_log2_reg);
            REG_WARP_SIZE:         prdata = DATA_BITS'(warp_size_reg);
            default:               prdata = '0;
        endcase
    end

    // Line address of the registered lane.
    assign scaled    = SHIFT_BITS'(index_reg) << element_size_log2_reg;
    assign line_mask = ~((ADDR_BITS'(1) << line_size_log2_reg) - ADDR_BITS'(1));
    assign line      = scaled[ADDR_BITS-1:0] & line_mask;

    // Warp closes at the lane limit or at the end of a row.
    always_comb
    begin
        warp_limit = CMP_BITS'(warp_size_reg);
        if (warp_size_reg == '0)
        begin
            warp_limit = CMP_BITS'(1);
        end
        else if (CMP_BITS'(warp_size_reg) > CMP_BITS'(MAX_LANES))
        begin
            warp_limit = CMP_BITS'(MAX_LANES);
        end
    end

    assign lanes_seen = CMP_BITS'(lane_position_reg) + CMP_BITS'(1);
    assign close      = end_of_row_reg || (lanes_seen >= warp_limit);

    // A closing lane waits until the previous warp leaves the drain buffer;
    // its last word may be taken in the same cycle.
    assign out_take    = out_ch.valid && out_ch.ready;
    assign drain_free  = (drain_count_reg == '0) ||
                         (out_take && (drain_count_reg == LANE_BITS'(1)));
    assign advance     = in_valid_reg && (!close || drain_free);
    assign in_ch.ready = !in_valid_reg || advance;

    assign set_ctrl.insert = advance;
    assign set_ctrl.flush  = close;

    wac_line_set u_line_set (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (set_ctrl),
        .line         (line),
        .merged       (merged),
        .merged_count (merged_count)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            index_reg         <= in_ch.element_index;
            end_of_row_reg    <= in_ch.end_of_row;
            first_of_pass_reg <= in_ch.first_of_pass;
        end
    end

    // Contiguity tracking: a run restarts on a break and ends at one line.
    always_comb
    begin
        logic [RUN_BITS-1:0]  run;
        logic [LOG2_BITS-1:0] span;
        logic [RUN_BITS-1:0]  run_limit;

        run                 = first_of_pass_reg ? '0 : run_counter_reg;
        coalesced_flag_next = first_of_pass_reg ? 1'b1 : coalesced_flag_reg;
        span                = line_size_log2_reg - element_size_log2_reg;
        run_limit           = RUN_BITS'(1) << span;

        if ((run != '0) &&
            !((index_reg != '0) && (previous_index_reg == index_reg - INDEX_BITS'(1))))
        begin
            coalesced_flag_next = 1'b0;
            run                 = '0;
        end
        if (run != RUN_MAX)
        begin
            run = run + RUN_BITS'(1);
        end
        if ((line_size_log2_reg >= element_size_log2_reg) && (run == run_limit))
        begin
            run = '0;
        end
        run_counter_next = run;
    end

    assign lane_position_next = close ? '0 : (lane_position_reg + LANE_BITS'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_position_reg  <= '0;
            run_counter_reg    <= '0;
            previous_index_reg <= '0;
            coalesced_flag_reg <= 1'b1;
        end
        else if (advance)
        begin
            lane_position_reg  <= lane_position_next;
            run_counter_reg    <= run_counter_next;
            previous_index_reg <= index_reg;
            coalesced_flag_reg <= coalesced_flag_next;
        end
    end

    // Drain buffer: loaded whole when a warp closes, shifted out word by word.
    always_comb
    begin
        drain_count_next = drain_count_reg;
        if (advance && close)
        begin
            drain_count_next = merged_count;
        end
        else if (out_take)
        begin
            drain_count_next = drain_count_reg - LANE_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_count_reg <= '0;
        end
        else
        begin
            drain_count_reg <= drain_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && close)
        begin
            drain_reg      <= merged;
            drain_flag_reg <= coalesced_flag_next;
        end
        else if (out_take)
        begin
            for (int k = 0; k < MAX_LANES - 1; k++)
            begin
                drain_reg[k] <= drain_reg[k+1];
            end
        end
    end

    // Output word.
    assign out_ch.valid           = drain_count_reg != '0;
    assign out_ch.line_address    = drain_reg[0];
    assign out_ch.last_of_warp    = drain_count_reg == LANE_BITS'(1);
    assign out_ch.fully_coalesced = drain_flag_reg;

`ifndef SYNTHESIS
    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        drain_count_reg <= LANE_BITS'(MAX_LANES))
        else $error("drain buffer holds more lines than lanes");

    a_close_needs_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && close) |-> ((drain_count_reg == '0) ||
                                (out_take && (drain_count_reg == LANE_BITS'(1)))))
        else $error("warp closed while previous warp still draining");

    a_close_gives_output: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && close) |=> out_ch.valid)
        else $error("closed warp produced no line address");

    a_lane_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lane_position_reg < LANE_BITS'(MAX_LANES))
        else $error("lane position beyond widest warp");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Warp access coalescer testbench
// Feeds lane words through the input channel and programs the three size
// registers over APB between phases. A scoreboard tracks the line set, the
// warp position and the contiguity run, and so predicts every line address
// word. Each word taken from the output channel is compared against the
// oldest prediction. Both channels idle at random. One phase holds the
// receiver off long enough to back the block up into its input.
// ----------------------------------------------------------------------------

import wac_pkg::*;

// One predicted output word.
typedef struct {
    line_t line_address;
    bit    last_of_warp;
    bit    fully_coalesced;
} line_word_t;

class line_scoreboard;
    logic [LOG2_BITS-1:0] elem_log2;
    logic [LOG2_BITS-1:0] line_log2;
    logic [WARP_BITS-1:0] warp_cfg;
    line_t                warp_lines[$];
    int                   lane_count;
    logic [RUN_BITS-1:0]  run_len;
    index_t               prev_idx;
    bit                   contig_flag;
    line_word_t           pending_lines[$];
    int                   errors;

    function new();
        elem_log2   = ELEMENT_SIZE_LOG2_RST;
        line_log2   = LINE_SIZE_LOG2_RST;
        warp_cfg    = WARP_SIZE_RST;
        lane_count  = 0;
        run_len     = '0;
        prev_idx    = '0;
        contig_flag = 1'b1;
        errors      = 0;
    endfunction

    function void set_reg(reg_index_t ri, logic [DATA_BITS-1:0] value);
        case (ri)
            REG_ELEMENT_SIZE_LOG2: elem_log2 = value[LOG2_BITS-1:0];
            REG_LINE_SIZE_LOG2:    line_log2 = value[LOG2_BITS-1:0];
            REG_WARP_SIZE:         warp_cfg  = value[WARP_BITS-1:0];
            default: ;
        endcase
    endfunction

    // Account for one accepted lane word; queue the warp's lines if it closes.
    function void take_lane(index_t idx, bit eor, bit fop);
        logic [63:0] wide;
        line_t       ln;
        int          pos;
        int          lanes;
        logic [31:0] span;
        line_word_t  w;

        // Scale to bytes, wrap to 32 bits and round down to the line.
        wide = {40'b0, idx} << elem_log2;
        ln   = wide[31:0] & ~((32'd1 << line_log2) - 32'd1);

        // Sorted insertion without duplicates.
        pos = 0;
        while (pos < warp_lines.size() && warp_lines[pos] < ln)
            pos++;
        if (!(pos < warp_lines.size() && warp_lines[pos] == ln) &&
            warp_lines.size() < MAX_LANES)
            warp_lines.insert(pos, ln);

        // Contiguity run: a new pass restarts it, a gap clears the flag.
        if (fop)
        begin
            run_len     = '0;
            contig_flag = 1'b1;
        end
        if (run_len != 0 && !(idx != 0 && prev_idx == index_t'(idx - 1'b1)))
        begin
            contig_flag = 1'b0;
            run_len     = '0;
        end
        prev_idx = idx;
        if (run_len != RUN_MAX)
            run_len++;
        if (line_log2 >= elem_log2)
        begin
            span = 32'd1 << (line_log2 - elem_log2);
            if ({18'b0, run_len} == span)
                run_len = '0;
        end

        // Warp closes on a full warp or at the end of a row.
        lanes = warp_cfg;
        if (lanes == 0)
            lanes = 1;
        if (lanes > MAX_LANES)
            lanes = MAX_LANES;
        lane_count++;
        if (eor || lane_count >= lanes)
        begin
            for (int k = 0; k < warp_lines.size(); k++)
            begin
                w.line_address    = warp_lines[k];
                w.last_of_warp    = (k == warp_lines.size() - 1);
                w.fully_coalesced = contig_flag;
                pending_lines.insert(pending_lines.size(), w);
            end
            warp_lines.delete();
            lane_count = 0;
        end
    endfunction

    // Compare one received word with the oldest prediction.
    function void check_line(line_t addr, bit last, bit fc);
        line_word_t w;

        if (pending_lines.size() == 0)
        begin
            $display("%0t: unexpected line word, expected none, actual addr=%h last=%0b flag=%0b",
                     $time, addr, last, fc);
            errors++;
            return;
        end
        w = pending_lines.pop_front();
        if (w.line_address != addr)
        begin
            $display("%0t: line_address mismatch, expected %h actual %h",
                     $time, w.line_address, addr);
            errors++;
        end
        if (w.last_of_warp != last)
        begin
            $display("%0t: last_of_warp mismatch at %h, expected %0b actual %0b",
                     $time, w.line_address, w.last_of_warp, last);
            errors++;
        end
        if (w.fully_coalesced != fc)
        begin
            $display("%0t: fully_coalesced mismatch at %h, expected %0b actual %0b",
                     $time, w.line_address, w.fully_coalesced, fc);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 32;
    localparam int NUM_PHASES   = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0]  pwdata;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;

    wac_in_if  in_ch ();
    wac_out_if out_ch ();

    line_scoreboard sb = new();

    // Shared controls: no idling on either side, and a receiver hold-off.
    bit quiet;
    int hold_len;
    int cycles;

    warp_access_coalescer u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: check each taken word, then pick the next ready value.
    initial
    begin : receiver
        int hold_left;

        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready)
                sb.check_line(out_ch.line_address, out_ch.last_of_warp,
                              out_ch.fully_coalesced);
            if (hold_len != 0)
            begin
                hold_left = hold_len;
                hold_len  = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= quiet || ($urandom_range(0, 99) >= 22);
        end
    end

    // Write all three size registers back to back over APB.
    task automatic program_regs(input logic [LOG2_BITS-1:0] elem,
                                input logic [LOG2_BITS-1:0] line,
                                input logic [WARP_BITS-1:0] warp);
        reg_index_t           ri;
        logic [DATA_BITS-1:0] value;

        for (int r = 0; r < 3; r++)
        begin
            ri    = reg_index_t'(r);
            value = (ri == REG_ELEMENT_SIZE_LOG2) ? DATA_BITS'(elem) :
                    (ri == REG_LINE_SIZE_LOG2)    ? DATA_BITS'(line) :
                                                    DATA_BITS'(warp);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {ri, 2'b00};
            pwdata  <= value;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            sb.set_reg(ri, value);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one lane word, with random idle cycles ahead of it.
    task automatic send_lane(input index_t idx, input bit eor, input bit fop);
        while (!quiet && $urandom_range(0, 99) < 22)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.element_index <= idx;
        in_ch.end_of_row    <= eor;
        in_ch.first_of_pass <= fop;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.take_lane(idx, eor, fop);
    endtask

    // Stop offering and wait until every predicted word has been taken.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_lines.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Main sequence.
    initial
    begin : stimulus
        index_t               cur_idx;
        index_t               idx;
        int                   row_left;
        int                   pick;
        bit                   pass_start;
        bit                   eor;
        logic [LOG2_BITS-1:0] elem;
        logic [LOG2_BITS-1:0] line;
        logic [WARP_BITS-1:0] warp;

        cycles              = 0;
        quiet               = 1'b0;
        hold_len            = 0;
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_ch.valid         = 1'b0;
        in_ch.element_index = '0;
        in_ch.end_of_row    = 1'b0;
        in_ch.first_of_pass = 1'b0;
        cur_idx             = '0;
        row_left            = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset sizes: pass restart mid-warp, a gap, duplicates, index extremes.
        send_lane(24'd0, 1'b0, 1'b1);
        send_lane(24'd1, 1'b0, 1'b0);
        send_lane(24'd2, 1'b0, 1'b1);
        send_lane(24'd40, 1'b0, 1'b0);
        send_lane(24'hFFFFFF, 1'b0, 1'b0);
        send_lane(24'hFFFFFF, 1'b1, 1'b0);
        send_lane(24'd0, 1'b1, 1'b1);
        // Index zero never continues a run.
        send_lane(24'd0, 1'b1, 1'b0);
        settle();

        // Warp size zero acts as one lane; byte elements and byte lines.
        program_regs(4'd0, 4'd0, 6'd0);
        send_lane(24'd5, 1'b0, 1'b1);
        send_lane(24'd6, 1'b0, 1'b0);
        send_lane(24'hABCDEF, 1'b0, 1'b0);
        settle();

        // Element larger than a line, warp size above the lane count.
        program_regs(4'd8, 4'd3, 6'd63);
        send_lane(24'd100, 1'b0, 1'b1);
        send_lane(24'd101, 1'b0, 1'b0);
        send_lane(24'd300, 1'b1, 1'b0);
        settle();

        // Largest shifts wrap the address; then lower the warp size mid-warp.
        program_regs(4'd15, 4'd15, 6'd32);
        send_lane(24'hFFFFFF, 1'b0, 1'b1);
        send_lane(24'h800000, 1'b0, 1'b0);
        send_lane(24'd1, 1'b0, 1'b0);
        settle();
        program_regs(4'd15, 4'd15, 6'd2);
        send_lane(24'd2, 1'b0, 1'b0);
        settle();

        // Random phases: rows of mostly contiguous indices with some noise.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: begin elem = 4'd0; line = 4'd0;  warp = 6'd1;  end
                1: begin elem = 4'd0; line = 4'd12; warp = 6'd32; end
                2: begin elem = 4'd8; line = 4'd12; warp = 6'd17; end
                // Short warps so that several close during the hold-off.
                3: begin elem = 4'd2; line = 4'd7;  warp = 6'd4;  end
                default:
                begin
                    elem = $urandom_range(0, 8);
                    line = $urandom_range(elem, 12);
                    if ($urandom_range(0, 5) == 0)
                    begin
                        elem = $urandom_range(0, 15);
                        line = $urandom_range(0, 15);
                    end
                    warp = $urandom_range(1, 32);
                    if ($urandom_range(0, 5) == 0)
                        warp = $urandom_range(0, 63);
                end
            endcase
            program_regs(elem, line, warp);

            quiet = (ph == 5 || ph == 6);
            if (ph == 3)
                hold_len = 400;

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                pass_start = 1'b0;
                if (row_left == 0)
                begin
                    row_left   = $urandom_range(1, 40);
                    pass_start = ($urandom_range(0, 3) == 0);
                    if ($urandom_range(0, 2) == 0)
                        cur_idx = index_t'($urandom());
                end
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    idx = index_t'($urandom());
                else if (pick < 14)
                    idx = cur_idx + index_t'($urandom_range(1, 64));
                else if (pick < 18)
                    idx = cur_idx;
                else
                    idx = cur_idx + 1'b1;
                eor = (row_left == 1) || ($urandom_range(0, 49) == 0);
                row_left--;
                send_lane(idx, eor, pass_start);
                cur_idx = idx;
            end
            settle();
        end

        quiet = 1'b0;
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/wac_pkg.sv
design/wac_channels.sv
design/wac_line_set.sv
design/warp_access_coalescer.sv
tb/sv/testbench.sv
